>>> src/dwf_pkg.sv
// ----------------------------------------------------------------------------
// dwf_pkg
// shared constants and types of the duplicate word filter
// ----------------------------------------------------------------------------
`default_nettype none

package dwf_pkg;

    localparam int MAX_WORDS_DEF      = 128;
    localparam int MAX_WORD_BYTES_DEF = 32;

    localparam logic [7:0] SEP_CHAR = 8'h20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN_RD,
        S_LEN_CHK,
        S_BYTE_RD,
        S_BYTE_CHK,
        S_EMIT_RD,
        S_EMIT_PUT,
        S_SEP,
        S_END
    } t_state;

endpackage

`default_nettype wire

>>> src/duplicate_word_filter_core.sv
// ----------------------------------------------------------------------------
// duplicate_word_filter_core
// passes on each distinct word of a sentence, while its word table has room, once
// ----------------------------------------------------------------------------
// A sentence enters one byte per beat, with i_sentence_last on its final
// byte. A byte that does not end a word is only written to the pending
// word buffer. A word end (space, or the last byte) walks the kept words
// of this sentence in the word memory: each kept word's length is checked,
// and where lengths match its bytes are compared one by one. A new word
// then goes out byte by byte plus the trailing space, and is copied into
// the word memory as it goes while the table has room. The word memory is
// single ported, with a registered read. Results leave through a registered
// output stage, so a waiting result does not stop input collection of the
// next bytes. A sentence end that emits nothing gives one empty marker
// beat. No clearing pass after reset: the fill count of kept words bounds
// every read.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_word_filter_core #(
    parameter int MAX_WORDS      = dwf_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_BYTES = dwf_pkg::MAX_WORD_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input beats
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_sentence_last,
    // result beats
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_run_last,
    output logic            o_sentence_end,
    output logic            o_table_full,
    output logic            o_word_truncated
);

    localparam int PI    = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
    localparam int WI    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int LW    = $clog2(MAX_WORD_BYTES + 1);
    localparam int DEPTH = MAX_WORDS * MAX_WORD_BYTES;
    localparam int BA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [LW-1:0] MWB_L = LW'(MAX_WORD_BYTES);
    localparam logic [CW-1:0] MW_C  = CW'(MAX_WORDS);
    localparam logic [BA-1:0] MWB_B = BA'(MAX_WORD_BYTES);

    dwf_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;     // kept words
    logic [CW-1:0] r_w, n_w;             // word under compare
    logic [LW-1:0] r_i, n_i;             // byte index
    logic [LW-1:0] r_plen, n_plen;       // pending length
    logic          r_ovf, n_ovf;         // pending word was cut
    logic          r_last, n_last;       // word end came with sentence end
    logic          r_store, n_store;     // table has room for a new word

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_has, n_out_has;
    logic          r_out_rlast, n_out_rlast;
    logic          r_out_send, n_out_send;
    logic          r_out_full, n_out_full;
    logic          r_out_trunc, n_out_trunc;

    // memory side
    logic          pend_we;
    logic [7:0]    pend_rdata;
    logic          seen_we;
    logic [BA-1:0] seen_addr;
    logic [7:0]    seen_rdata;
    logic          len_we;
    logic [LW-1:0] len_rdata;
    logic [WI-1:0] word_base;

    // input side helpers
    logic          in_acc;
    logic          is_sep;
    logic          add_byte;
    logic [LW-1:0] plen_new;
    logic          slot_free;
    logic          last_word;
    logic          last_byte;

    assign in_acc    = i_in_valid && (r_state == dwf_pkg::S_IDLE);
    assign is_sep    = (i_char_in == dwf_pkg::SEP_CHAR);
    assign add_byte  = !is_sep && (r_plen < MWB_L);
    assign plen_new  = add_byte ? r_plen + LW'(1) : r_plen;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign last_word = ((r_w + CW'(1)) == r_count);
    assign last_byte = ((r_i + LW'(1)) == r_plen);

    // emission writes the new word at the fill slot, compare reads word w
    assign word_base = (r_state == dwf_pkg::S_EMIT_PUT) ? r_count[WI-1:0] : r_w[WI-1:0];
    assign seen_addr = BA'(word_base) * MWB_B + BA'(r_i);
    assign pend_we   = in_acc && add_byte;
    assign seen_we   = (r_state == dwf_pkg::S_EMIT_PUT) && slot_free && r_store;
    assign len_we    = (r_state == dwf_pkg::S_SEP) && slot_free && r_store;

    dwf_store #(
        .MAX_WORDS      (MAX_WORDS),
        .MAX_WORD_BYTES (MAX_WORD_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_pend_we    (pend_we),
        .i_pend_waddr (r_plen[PI-1:0]),
        .i_pend_wdata (i_char_in),
        .i_pend_raddr (r_i[PI-1:0]),
        .o_pend_rdata (pend_rdata),
        .i_seen_we    (seen_we),
        .i_seen_addr  (seen_addr),
        .i_seen_wdata (pend_rdata),
        .o_seen_rdata (seen_rdata),
        .i_len_we     (len_we),
        .i_len_waddr  (r_count[WI-1:0]),
        .i_len_wdata  (r_plen),
        .i_len_raddr  (r_w[WI-1:0]),
        .o_len_rdata  (len_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dwf_pkg::S_IDLE: begin
                if (in_acc && (is_sep || i_sentence_last)) begin
                    if (plen_new == '0) begin
                        n_state = i_sentence_last ? dwf_pkg::S_END : dwf_pkg::S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = dwf_pkg::S_EMIT_RD;
                    end else begin
                        n_state = dwf_pkg::S_LEN_RD;
                    end
                end
            end
            dwf_pkg::S_LEN_RD: n_state = dwf_pkg::S_LEN_CHK;
            dwf_pkg::S_LEN_CHK: begin
                if (len_rdata == r_plen) begin
                    n_state = dwf_pkg::S_BYTE_RD;
                end else begin
                    n_state = last_word ? dwf_pkg::S_EMIT_RD : dwf_pkg::S_LEN_RD;
                end
            end
            dwf_pkg::S_BYTE_RD: n_state = dwf_pkg::S_BYTE_CHK;
            dwf_pkg::S_BYTE_CHK: begin
                if (seen_rdata != pend_rdata) begin
                    n_state = last_word ? dwf_pkg::S_EMIT_RD : dwf_pkg::S_LEN_RD;
                end else if (last_byte) begin
                    n_state = dwf_pkg::S_END;
                end else begin
                    n_state = dwf_pkg::S_BYTE_RD;
                end
            end
            dwf_pkg::S_EMIT_RD: n_state = dwf_pkg::S_EMIT_PUT;
            dwf_pkg::S_EMIT_PUT: begin
                if (slot_free) begin
                    n_state = last_byte ? dwf_pkg::S_SEP : dwf_pkg::S_EMIT_RD;
                end
            end
            dwf_pkg::S_SEP: begin
                if (slot_free) begin
                    n_state = dwf_pkg::S_IDLE;
                end
            end
            dwf_pkg::S_END: begin
                if (!r_last || slot_free) begin
                    n_state = dwf_pkg::S_IDLE;
                end
            end
            default: n_state = dwf_pkg::S_IDLE;
        endcase
    end

    // datapath and output beat
    always_comb begin
        n_count     = r_count;
        n_w         = r_w;
        n_i         = r_i;
        n_plen      = r_plen;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_store     = r_store;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_has   = r_out_has;
        n_out_rlast = r_out_rlast;
        n_out_send  = r_out_send;
        n_out_full  = r_out_full;
        n_out_trunc = r_out_trunc;
        case (r_state)
            dwf_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_plen  = plen_new;
                    n_ovf   = r_ovf || (!is_sep && !add_byte);
                    n_last  = i_sentence_last;
                    n_store = (r_count < MW_C);
                    n_w     = '0;
                    n_i     = '0;
                    if (!i_sentence_last && is_sep && plen_new == '0) begin
                        n_ovf = '0;
                    end
                end
            end
            dwf_pkg::S_LEN_CHK: begin
                n_i = '0;
                if (len_rdata != r_plen) begin
                    n_w = r_w + CW'(1);
                end
            end
            dwf_pkg::S_BYTE_CHK: begin
                if (seen_rdata != pend_rdata) begin
                    n_w = r_w + CW'(1);
                    n_i = '0;
                end else if (!last_byte) begin
                    n_i = r_i + LW'(1);
                end
            end
            dwf_pkg::S_EMIT_PUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = pend_rdata;
                    n_out_has   = 1'b1;
                    n_out_rlast = 1'b0;
                    n_out_send  = 1'b0;
                    n_out_full  = !r_store;
                    n_out_trunc = r_ovf;
                    n_i         = r_i + LW'(1);
                end
            end
            dwf_pkg::S_SEP: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = dwf_pkg::SEP_CHAR;
                    n_out_has   = 1'b1;
                    n_out_rlast = 1'b1;
                    n_out_send  = r_last;
                    n_out_full  = !r_store;
                    n_out_trunc = r_ovf;
                    n_plen      = '0;
                    n_ovf       = 1'b0;
                    if (r_last) begin
                        n_count = '0;
                    end else if (r_store) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            dwf_pkg::S_END: begin
                if (!r_last) begin
                    n_plen = '0;
                    n_ovf  = 1'b0;
                end else if (slot_free) begin
                    // empty end marker
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_has   = 1'b0;
                    n_out_rlast = 1'b1;
                    n_out_send  = 1'b1;
                    n_out_full  = 1'b0;
                    n_out_trunc = 1'b0;
                    n_plen      = '0;
                    n_ovf       = 1'b0;
                    n_count     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dwf_pkg::S_IDLE;
            r_count     <= '0;
            r_plen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_plen      <= n_plen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_i         <= n_i;
        r_last      <= n_last;
        r_store     <= n_store;
        r_out_byte  <= n_out_byte;
        r_out_has   <= n_out_has;
        r_out_rlast <= n_out_rlast;
        r_out_send  <= n_out_send;
        r_out_full  <= n_out_full;
        r_out_trunc <= n_out_trunc;
    end

    assign o_in_stall       = (r_state != dwf_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_has_byte       = r_out_has;
    assign o_run_last       = r_out_rlast;
    assign o_sentence_end   = r_out_send;
    assign o_table_full     = r_out_full;
    assign o_word_truncated = r_out_trunc;

endmodule

`default_nettype wire

>>> src/dwf_store.sv
// ----------------------------------------------------------------------------
// dwf_store
// pending word buffer, kept word bytes and kept word lengths
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_store #(
    parameter int  MAX_WORDS      = dwf_pkg::MAX_WORDS_DEF,
    parameter int  MAX_WORD_BYTES = dwf_pkg::MAX_WORD_BYTES_DEF,
    localparam int PI    = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1,
    localparam int WI    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
    localparam int LW    = $clog2(MAX_WORD_BYTES + 1),
    localparam int DEPTH = MAX_WORDS * MAX_WORD_BYTES,
    localparam int BA    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    // pending word
    input  wire logic                  i_pend_we,
    input  wire logic [PI-1:0]         i_pend_waddr,
    input  wire logic [7:0]            i_pend_wdata,
    input  wire logic [PI-1:0]         i_pend_raddr,
    output logic      [7:0]            o_pend_rdata,
    // kept word bytes
    input  wire logic                  i_seen_we,
    input  wire logic [BA-1:0]         i_seen_addr,
    input  wire logic [7:0]            i_seen_wdata,
    output logic      [7:0]            o_seen_rdata,
    // kept word lengths
    input  wire logic                  i_len_we,
    input  wire logic [WI-1:0]         i_len_waddr,
    input  wire logic [LW-1:0]         i_len_wdata,
    input  wire logic [WI-1:0]         i_len_raddr,
    output logic      [LW-1:0]         o_len_rdata
);

    logic [7:0]    m_pend [0:MAX_WORD_BYTES-1];
    logic [7:0]    m_seen [0:DEPTH-1];
    logic [LW-1:0] m_len  [0:MAX_WORDS-1];

    always_ff @(posedge i_clk) begin
        if (i_pend_we) begin
            m_pend[i_pend_waddr] <= i_pend_wdata;
        end
        o_pend_rdata <= m_pend[i_pend_raddr];
    end

    // single port: one address serves both the read and the write
    always_ff @(posedge i_clk) begin
        if (i_seen_we) begin
            m_seen[i_seen_addr] <= i_seen_wdata;
        end
        o_seen_rdata <= m_seen[i_seen_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            m_len[i_len_waddr] <= i_len_wdata;
        end
        o_len_rdata <= m_len[i_len_raddr];
    end

endmodule

`default_nettype wire

>>> src/dwf_checker.sv
// ----------------------------------------------------------------------------
// dwf_checker
// port level checks of the duplicate word filter
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_has_byte,
    input wire logic       o_run_last,
    input wire logic       o_sentence_end
);

    // a stalled result beat stays offered
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped under stall");

    // an empty beat is only the end marker
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |->
            o_run_last && o_sentence_end && (o_out_byte == 8'h00))
        else $error("empty beat is not a clean end marker");

    // the sentence end closes its run
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sentence_end |-> o_run_last)
        else $error("sentence end without run end");

    // a run with bytes ends on the trailing space
    a_run_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_byte && o_run_last |-> (o_out_byte == 8'h20))
        else $error("run does not end with a space");

endmodule

bind duplicate_word_filter_core dwf_checker u_dwf_checker (.*);

`default_nettype wire

>>> sim/duplicate_word_filter_core_tb.sv
// ----------------------------------------------------------------------------
// duplicate_word_filter_core_tb
// self-checking bench of the duplicate word filter
// ----------------------------------------------------------------------------
// Sentence bytes are queued by an initial block and offered by a clocked
// driver. A word-level predictor works out every result beat of each
// accepted byte. A clocked monitor checks the result beats in order against
// that prediction. Idle and stall rates change from phase to phase. One
// phase holds the result side off for a long stretch, and the sender waits
// for the block to drain at each phase boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicate_word_filter_core_tb;

    localparam int N_WORDS   = dwf_pkg::MAX_WORDS_DEF;
    localparam int N_BYTES   = dwf_pkg::MAX_WORD_BYTES_DEF;
    localparam int WATCH_MAX = 200000;
    localparam int TAIL_CYC  = 2000;
    localparam int HOLD_CYC  = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] byte_v;
        logic       has;
        logic       run_last;
        logic       sent_end;
        logic       full;
        logic       trunc;
    } t_out_beat;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       sent_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       sent_end;
    logic       table_full;
    logic       word_trunc;

    duplicate_word_filter_core DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_char_in        (char_in),
        .i_sentence_last  (sent_last),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_byte       (out_byte),
        .o_has_byte       (has_byte),
        .o_run_last       (run_last),
        .o_sentence_end   (sent_end),
        .o_table_full     (table_full),
        .o_word_truncated (word_trunc)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state: kept words of the current sentence and the open word
    logic [7:0] kept_bytes [N_WORDS][N_BYTES];
    int         kept_len   [N_WORDS];
    int         kept_cnt;
    logic [7:0] open_bytes [N_BYTES];
    int         open_len;
    bit         open_ovf;

    t_in_beat   byte_queue [$];
    t_out_beat  expected_beats [$];
    int         errors;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_cnt;
    bit         hold_phase;
    bit         sender_gate;
    bit         all_queued;
    int         quiet_cycles;

    function automatic bit open_word_known();
        bit same;
        for (int w = 0; w < kept_cnt; w++) begin
            if (kept_len[w] == open_len) begin
                same = 1'b1;
                for (int i = 0; i < open_len; i++)
                    if (kept_bytes[w][i] != open_bytes[i]) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // results of one accepted byte, appended to expected_beats
    task automatic predict_filter(input t_in_beat b);
        t_out_beat r;
        logic      full;
        int        n;
        n = 0;
        if (b.ch != dwf_pkg::SEP_CHAR) begin
            if (open_len < N_BYTES) begin
                open_bytes[open_len] = b.ch;
                open_len++;
            end else begin
                open_ovf = 1'b1;
            end
        end
        if ((b.ch == dwf_pkg::SEP_CHAR || b.last) && open_len > 0) begin
            if (!open_word_known()) begin
                full = 1'b0;
                if (kept_cnt < N_WORDS) begin
                    for (int i = 0; i < open_len; i++)
                        kept_bytes[kept_cnt][i] = open_bytes[i];
                    kept_len[kept_cnt] = open_len;
                    kept_cnt++;
                end else begin
                    full = 1'b1;
                end
                for (int i = 0; i <= open_len; i++) begin
                    r = '0;
                    r.byte_v = (i == open_len) ? dwf_pkg::SEP_CHAR : open_bytes[i];
                    r.has    = 1'b1;
                    r.full   = full;
                    r.trunc  = open_ovf;
                    expected_beats.push_back(r);
                    n++;
                end
            end
            open_len = 0;
            open_ovf = 1'b0;
        end
        if (b.last) begin
            if (n == 0) begin
                expected_beats.push_back('0);
                n = 1;
            end
            r = expected_beats.pop_back();
            r.sent_end = 1'b1;
            expected_beats.push_back(r);
            kept_cnt = 0;
            open_len = 0;
            open_ovf = 1'b0;
        end
        if (n > 0) begin
            r = expected_beats.pop_back();
            r.run_last = 1'b1;
            expected_beats.push_back(r);
        end
    endtask

    // driver: a payload stays put while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            char_in   <= '0;
            sent_last <= 1'b0;
        end else begin
            if (in_valid && !in_stall) predict_filter({char_in, sent_last});
            if (!in_valid || !in_stall) begin
                if (sender_gate && byte_queue.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                    t_in_beat nb;
                    nb = byte_queue.pop_front();
                    in_valid  <= 1'b1;
                    char_in   <= nb.ch;
                    sent_last <= nb.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off counted here
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
        end else if (hold_phase && hold_cnt < HOLD_CYC) begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: compare each accepted result beat with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            t_out_beat got;
            t_out_beat want;
            got = {out_byte, has_byte, run_last, sent_end, table_full, word_trunc};
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (got.byte_v !== want.byte_v) begin
                    $display("%0t: out_byte exp %h got %h", $time, want.byte_v, got.byte_v);
                    errors++;
                end
                if (got.has !== want.has) begin
                    $display("%0t: has_byte exp %b got %b", $time, want.has, got.has);
                    errors++;
                end
                if (got.run_last !== want.run_last) begin
                    $display("%0t: run_last exp %b got %b", $time, want.run_last,
                             got.run_last);
                    errors++;
                end
                if (got.sent_end !== want.sent_end) begin
                    $display("%0t: sentence_end exp %b got %b", $time, want.sent_end,
                             got.sent_end);
                    errors++;
                end
                if (got.full !== want.full) begin
                    $display("%0t: table_full exp %b got %b", $time, want.full, got.full);
                    errors++;
                end
                if (got.trunc !== want.trunc) begin
                    $display("%0t: word_truncated exp %b got %b", $time, want.trunc,
                             got.trunc);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (byte_queue.size() > 0 || expected_beats.size() > 0 || !all_queued)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("duplicate_word_filter_core_tb failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic l);
        byte_queue.push_back({c, l});
    endtask

    task automatic push_word(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    // random sentence from a small vocabulary so that repeats are common
    task automatic push_sentence(input int n_words);
        int len;
        for (int w = 0; w < n_words; w++) begin
            for (int s = $urandom_range(2, 1); s > 0; s--) push_byte(dwf_pkg::SEP_CHAR, 1'b0);
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 30) : $urandom_range(3, 1);
            for (int i = 0; i < len; i++) begin
                logic [7:0] c;
                c = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'("a" + $urandom_range(2));
                if (c == dwf_pkg::SEP_CHAR) c = 8'h21;
                push_byte(c, 1'b0);
            end
        end
        push_byte(($urandom_range(3) == 0) ? dwf_pkg::SEP_CHAR : 8'("a" + $urandom_range(2)),
                  1'b1);
    endtask

    // wait until the queue is sent and every result has come
    task automatic drain();
        while (byte_queue.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_phase     = 1'b0;
        sender_gate    = 1'b1;
        all_queued     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: repeat, space runs, extreme bytes, empty end, long word
        push_word("ab  ab x");
        push_byte(dwf_pkg::SEP_CHAR, 1'b1);
        push_byte(dwf_pkg::SEP_CHAR, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(dwf_pkg::SEP_CHAR, 1'b0);
        push_byte(8'hff, 1'b1);
        for (int i = 0; i < N_BYTES + 3; i++) push_byte(8'h41 + i[7:0], 1'b0);
        push_byte(8'h7e, 1'b1);
        drain();

        // full table: more distinct one-byte words than it holds, then repeats
        for (int w = 0; w < N_WORDS + 2; w++) begin
            push_byte(8'h21 + w[7:0], 1'b0);
            push_byte(dwf_pkg::SEP_CHAR, 1'b0);
        end
        push_byte(8'h21 + 8'(N_WORDS), 1'b0);
        push_byte(dwf_pkg::SEP_CHAR, 1'b0);
        push_byte(8'h21, 1'b1);
        drain();

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            hold_phase = (ph == 4);
            for (int s = 0; s < 2; s++) push_sentence($urandom_range(4, 2));
            drain();
        end

        all_queued = 1'b1;
        repeat (TAIL_CYC) begin
            @(posedge clk);
            if (expected_beats.size() == 0) break;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("duplicate_word_filter_core_tb passed");
        else
            $display("duplicate_word_filter_core_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
